[design/utfv_pkg.sv]
// ----------------------------------------------------------------------------
// utfv_pkg
// Types and constants shared by the UTF-8 name validator.
// ----------------------------------------------------------------------------
package utfv_pkg;

    localparam int CP_W    = 21;
    localparam int LEN_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN_2B   = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h010000;
    localparam logic [CP_W-1:0] CP_USCORE   = 21'h00005F;

    localparam logic [LEN_W-1:0] COUNT_MAX  = 8'hFF;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_EMPTY    = 4'd1,
        ST_BAD_UTF8 = 4'd2,
        ST_BAD_CHAR = 4'd3,
        ST_LEAD_US  = 4'd4,
        ST_TWO_US   = 4'd5,
        ST_SHORT    = 4'd6,
        ST_LONG     = 4'd7,
        ST_TRAIL_US = 4'd8
    } status_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LENGTH = 2'd0,
        CFG_MAX_LENGTH = 2'd1,
        CFG_EXTRA_LOW  = 2'd2,
        CFG_EXTRA_HIGH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0] min_length;
        logic [LEN_W-1:0] max_length;
        logic [CP_W-1:0]  extra_low;
        logic [CP_W-1:0]  extra_high;
    } cfg_t;

    typedef struct packed {
        logic              en;
        op_t               op;
        logic [BYTE_W-1:0] byte_value;
    } step_t;

endpackage

[design/utfv_core.sv]
// ----------------------------------------------------------------------------
// utfv_core
// Per-name decode state: UTF-8 sequence tracking, character checks,
// underscore rules, first error latch and the end-of-name status.
// ----------------------------------------------------------------------------
module utfv_core
    import utfv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  step_t             step,
    input  cfg_t              cfg,
    output status_t           status,
    output logic [LEN_W-1:0]  char_count
);

    logic [CP_W-1:0]  partial_reg, partial_next;
    logic [1:0]       expect_reg, expect_next;
    logic [1:0]       seq_reg, seq_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             us_seen_reg, us_seen_next;
    logic             prev_us_reg, prev_us_next;
    status_t          err_reg, err_next;
    logic             byte_seen_reg, byte_seen_next;

    logic [CP_W-1:0]  shifted;
    logic [CP_W-1:0]  cp;
    logic             take;
    logic             seq_bad;
    logic             allowed;
    logic [LEN_W-1:0] count_inc;

    assign shifted = {partial_reg[CP_W-7:0], step.byte_value[5:0]};
    assign cp      = (expect_reg == 2'd0) ? {13'd0, step.byte_value} : shifted;

    assign seq_bad = (seq_reg == 2'd1 && shifted < CP_MIN_2B)
                  || (seq_reg == 2'd2 && shifted < CP_MIN_3B)
                  || (seq_reg == 2'd3 && shifted < CP_MIN_4B)
                  || (shifted > CP_MAX)
                  || (shifted >= CP_SURR_LO && shifted <= CP_SURR_HI);

    assign allowed = (cp >= 21'h41 && cp <= 21'h5A)
                  || (cp >= 21'h61 && cp <= 21'h7A)
                  || (cp >= 21'h30 && cp <= 21'h39)
                  || (cp == CP_USCORE)
                  || (cp >= cfg.extra_low && cp <= cfg.extra_high);

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;

    always_comb
    begin
        partial_next   = partial_reg;
        expect_next    = expect_reg;
        seq_next       = seq_reg;
        count_next     = count_reg;
        us_seen_next   = us_seen_reg;
        prev_us_next   = prev_us_reg;
        err_next       = err_reg;
        byte_seen_next = byte_seen_reg;
        take           = 1'b0;

        if (step.en)
        begin
            if (step.op == OP_END)
            begin
                partial_next   = '0;
                expect_next    = '0;
                seq_next       = '0;
                count_next     = '0;
                us_seen_next   = 1'b0;
                prev_us_next   = 1'b0;
                err_next       = ST_OK;
                byte_seen_next = 1'b0;
            end
            else
            begin
                byte_seen_next = 1'b1;
                if (err_reg == ST_OK)
                begin
                    if (expect_reg == 2'd0)
                    begin
                        // lead byte
                        if (!step.byte_value[7])
                            take = 1'b1;
                        else if (step.byte_value >= 8'hC2 && step.byte_value <= 8'hDF)
                        begin
                            partial_next = {16'd0, step.byte_value[4:0]};
                            expect_next  = 2'd1;
                            seq_next     = 2'd1;
                        end
                        else if (step.byte_value >= 8'hE0 && step.byte_value <= 8'hEF)
                        begin
                            partial_next = {17'd0, step.byte_value[3:0]};
                            expect_next  = 2'd2;
                            seq_next     = 2'd2;
                        end
                        else if (step.byte_value >= 8'hF0 && step.byte_value <= 8'hF4)
                        begin
                            partial_next = {18'd0, step.byte_value[2:0]};
                            expect_next  = 2'd3;
                            seq_next     = 2'd3;
                        end
                        else
                            err_next = ST_BAD_UTF8;
                    end
                    else if (step.byte_value[7:6] != 2'b10)
                        err_next = ST_BAD_UTF8;
                    else
                    begin
                        expect_next = expect_reg - 2'd1;
                        if (expect_reg != 2'd1)
                            partial_next = shifted;
                        else
                        begin
                            partial_next = '0;
                            seq_next     = '0;
                            if (seq_bad)
                                err_next = ST_BAD_UTF8;
                            else
                                take = 1'b1;
                        end
                    end
                end
            end
        end

        // complete code point: count, then character and underscore rules
        if (take)
        begin
            count_next = count_inc;
            if (!allowed)
                err_next = ST_BAD_CHAR;
            else if (cp == CP_USCORE)
            begin
                if (count_inc == 8'd1)
                    err_next = ST_LEAD_US;
                else if (us_seen_reg)
                    err_next = ST_TWO_US;
                else
                begin
                    us_seen_next = 1'b1;
                    prev_us_next = 1'b1;
                end
            end
            else
                prev_us_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            expect_reg    <= '0;
            seq_reg       <= '0;
            count_reg     <= '0;
            us_seen_reg   <= 1'b0;
            prev_us_reg   <= 1'b0;
            err_reg       <= ST_OK;
            byte_seen_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            expect_reg    <= expect_next;
            seq_reg       <= seq_next;
            count_reg     <= count_next;
            us_seen_reg   <= us_seen_next;
            prev_us_reg   <= prev_us_next;
            err_reg       <= err_next;
            byte_seen_reg <= byte_seen_next;
        end
    end

    always_comb
    begin
        if (!byte_seen_reg)
            status = ST_EMPTY;
        else if (err_reg != ST_OK)
            status = err_reg;
        else if (expect_reg != 2'd0)
            status = ST_BAD_UTF8;      // truncated tail
        else if (count_reg < cfg.min_length)
            status = ST_SHORT;
        else if (count_reg > cfg.max_length)
            status = ST_LONG;
        else if (prev_us_reg)
            status = ST_TRAIL_US;
        else
            status = ST_OK;
    end

    assign char_count = count_reg;

endmodule

[design/utf8_name_validator.sv]
// ----------------------------------------------------------------------------
// utf8_name_validator
// Strict UTF-8 decoder and name checker with one status per name.
// ----------------------------------------------------------------------------
// Input stream s_axis: one transfer per byte of a name (tuser = 0, byte in
// tdata), then one end marker (tuser = 1, tdata ignored).
// Output stream m_axis: one transfer per end marker carrying the status and
// the code point count (saturating at 255). Byte transfers give no output.
// Throughput: one input transfer per cycle, set by the single decode step
// between the input register and the name state registers, unless an end
// marker is held by a full, stalled output register. An end marker is
// accepted into the input register and its result is then registered in
// the output register, from which it shows on m_axis.
// If the receiver stalls, the result waits in the output register; bytes
// keep flowing, and a further end marker waits in the input register until
// the output register frees up.
// Reset clears both valid flags and the name state and loads the default
// limits (3..32 code points, extra range 0x400..0x52F).
// cfg_we/cfg_index/cfg_data write a limit register; write only when idle.
// ----------------------------------------------------------------------------
module utf8_name_validator
    import utfv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] byte_value
    input  logic                 s_axis_tuser,   // [0] operation

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [3:0] status, [11:4] char_count

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t              cfg_reg;

    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [LEN_W-1:0]  out_count_reg;

    logic              advance;
    step_t             step;
    status_t           status;
    logic [LEN_W-1:0]  char_count;

    // a byte never needs the output side; an end marker needs a free slot
    assign advance = in_valid_reg
                  && (in_op_reg == OP_BYTE || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign step.en         = advance;
    assign step.op         = in_op_reg;
    assign step.byte_value = in_byte_reg;

    utfv_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg_reg),
        .status     (status),
        .char_count (char_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length <= 8'd3;
            cfg_reg.max_length <= 8'd32;
            cfg_reg.extra_low  <= 21'h000400;
            cfg_reg.extra_high <= 21'h00052F;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_LENGTH: cfg_reg.min_length <= cfg_data[LEN_W-1:0];
                CFG_MAX_LENGTH: cfg_reg.max_length <= cfg_data[LEN_W-1:0];
                CFG_EXTRA_LOW:  cfg_reg.extra_low  <= cfg_data[CP_W-1:0];
                CFG_EXTRA_HIGH: cfg_reg.extra_high <= cfg_data[CP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= op_t'(s_axis_tuser);
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_op_reg == OP_END)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_op_reg == OP_END)
        begin
            out_status_reg <= status;
            out_count_reg  <= char_count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_count_reg, out_status_reg};

endmodule

[design/utfv_checker.sv]
// ----------------------------------------------------------------------------
// utfv_checker
// Port-level checks on the name validator, bound to the top level.
// ----------------------------------------------------------------------------
module utfv_checker
    import utfv_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= ST_TRAIL_US)
        else $error("status code out of range");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
        else $error("tdata padding not zero");

    // an empty name has decoded nothing
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] == ST_EMPTY |-> m_axis_tdata[11:4] == 8'd0)
        else $error("empty name with nonzero count");

    // a clean name has at least one complete code point
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[3:0] == ST_OK || m_axis_tdata[3:0] == ST_TRAIL_US)
        |-> m_axis_tdata[11:4] != 8'd0)
        else $error("accepted name with zero count");

endmodule

bind utf8_name_validator utfv_checker u_utfv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
